@@ sv/prlru_pkg.sv @@
// Shared types and constants for the page replacement frame table.
// No dependencies; compile this file first.
`default_nettype none

package prlru_pkg;

	localparam int FRAMES_DEF = 16;
	localparam int PAGE_W     = 16;
	localparam int FIDX_W     = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 5;

	typedef logic [PAGE_W-1:0]     page_t;
	typedef logic [FIDX_W-1:0]     fidx_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic {
		POLICY_FIFO = 1'b0,
		POLICY_LRU  = 1'b1
	} policy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLICY        = 4'd0,
		REG_FRAMES_IN_USE = 4'd1
	} reg_idx_t;

	// Control from the top level to the frame table.
	typedef struct packed {
		logic    clear;
		logic    step;
		policy_t policy;
	} prlru_ctl_t;

	// Lookup outcome for the reference presented to the table.
	typedef struct packed {
		logic  hit;
		logic  ev_valid;
		page_t ev_page;
	} prlru_look_t;

endpackage

`default_nettype wire

@@ sv/prlru_if.sv @@
// Valid/ready channel interfaces: page reference, result and register write.
// Depends on prlru_pkg.
`default_nettype none

interface prlru_req_if;
	logic              valid;
	logic              ready;
	prlru_pkg::page_t  page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface prlru_rsp_if;
	logic              valid;
	logic              ready;
	logic              hit;
	prlru_pkg::fidx_t  frame_index;
	logic              evicted_valid;
	prlru_pkg::page_t  evicted_page;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, output ready);
endinterface

interface prlru_cfg_if;
	logic                  valid;
	logic                  ready;
	prlru_pkg::cfg_idx_t   index;
	prlru_pkg::cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/prlru_table.sv @@
// Frame table: page tags, valid bits and age ranks, with the parallel lookup
// and the rank update for one reference. Depends on prlru_pkg.
`default_nettype none

module prlru_table #(
	parameter int FRAMES = prlru_pkg::FRAMES_DEF,
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int RANK_W = $clog2(FRAMES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire prlru_pkg::prlru_ctl_t ctl,
	input  wire logic [RANK_W-1:0]     n,
	input  wire prlru_pkg::page_t      page,
	output prlru_pkg::prlru_look_t     look,
	output logic [IDX_W-1:0]           slot
);

	prlru_pkg::page_t  page_q [FRAMES];
	logic [FRAMES-1:0] valid_q;
	logic [RANK_W-1:0] rank_q [FRAMES];

	logic [FRAMES-1:0] in_use;
	logic [FRAMES-1:0] hit_oh;
	logic [FRAMES-1:0] vic_oh;
	logic [IDX_W-1:0]  hit_slot;
	logic [IDX_W-1:0]  vic_slot;
	logic [RANK_W-1:0] old_rank;
	logic              hit_found;
	logic              vic_found;

	// Tag compare and victim search across every frame in use. The one-hot
	// vectors keep only the lowest matching index.
	always_comb begin
		hit_oh    = '0;
		vic_oh    = '0;
		hit_slot  = '0;
		vic_slot  = '0;
		hit_found = 1'b0;
		vic_found = 1'b0;
		old_rank  = '0;
		look.ev_page = '0;
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i] = (RANK_W'(i) < n);
			if (in_use[i] && valid_q[i] && page_q[i] == page && !hit_found) begin
				hit_oh[i] = 1'b1;
				hit_slot  = IDX_W'(i);
				hit_found = 1'b1;
			end
			if (in_use[i] && rank_q[i] == RANK_W'(1) && !vic_found) begin
				vic_oh[i] = 1'b1;
				vic_slot  = IDX_W'(i);
				vic_found = 1'b1;
			end
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (hit_oh[i]) begin
				old_rank = old_rank | rank_q[i];
			end
			if (vic_oh[i] && valid_q[i]) begin
				look.ev_page = look.ev_page | page_q[i];
			end
		end
		look.hit      = hit_found;
		look.ev_valid = !hit_found && |(vic_oh & valid_q);
		if (hit_found) begin
			look.ev_page = '0;
		end
		slot = hit_found ? hit_slot : vic_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= RANK_W'(i + 1);
			end
		end else if (ctl.clear) begin
			valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= RANK_W'(i + 1);
			end
		end else if (ctl.step) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (in_use[i]) begin
					if (hit_found) begin
						if (ctl.policy == prlru_pkg::POLICY_LRU) begin
							if (hit_oh[i]) begin
								rank_q[i] <= n;
							end else if (rank_q[i] > old_rank) begin
								rank_q[i] <= rank_q[i] - RANK_W'(1);
							end
						end
					end else if (vic_oh[i]) begin
						rank_q[i]  <= n;
						valid_q[i] <= 1'b1;
					end else if (rank_q[i] != '0) begin
						rank_q[i] <= rank_q[i] - RANK_W'(1);
					end
				end
			end
		end
	end

	// Page tags are only read behind their valid bits, so they need no reset.
	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.clear && !hit_found) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (vic_oh[i]) begin
					page_q[i] <= page;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/page_replacement_fifo_lru_core.sv @@
// Top level of the FIFO/LRU page replacement frame table.
// Depends on prlru_pkg, the channel interfaces and prlru_table.
//
//   channel  role    beat contents
//   -------  ------  --------------------------------------------------------
//   req      sink    page_number
//   rsp      source  hit, frame_index, evicted_valid, evicted_page
//   cfg      sink    index (0 policy, 1 frames_in_use), data
//
// A reference beat is captured in an input register. In the cycle that it
// leaves that register, the tag compare, victim pick and rank update for
// all frames finish, and the result lands in the output register. One
// reference per cycle is sustained while rsp is not stalled; the limit is
// the single lookup-and-update pass over the table.
// The input register moves on whenever the output register is empty or is
// being emptied, so a stalled rsp holds one item in each register and only
// then drops req.ready. Reset empties the table, selects LRU and uses the
// smaller of FRAMES and 16 frames. A write to a known register also empties
// the table; cfg.ready is always high.
`default_nettype none

module page_replacement_fifo_lru_core #(
	parameter int FRAMES = prlru_pkg::FRAMES_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	prlru_req_if.sink   req,
	prlru_rsp_if.source rsp,
	prlru_cfg_if.sink   cfg
);

	localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W  = $clog2(FRAMES + 1);
	localparam int N_RESET = (FRAMES < 16) ? FRAMES : 16;

	// Register file: the policy and the frame count, clamped to 1..FRAMES
	// at the time of the write.
	prlru_pkg::policy_t policy_q;
	logic [RANK_W-1:0]  n_q;

	logic cfg_wr;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= prlru_pkg::POLICY_LRU;
			n_q      <= RANK_W'(N_RESET);
		end else if (cfg_wr) begin
			if (cfg.index == prlru_pkg::REG_POLICY) begin
				policy_q <= prlru_pkg::policy_t'(cfg.data[0]);
			end else if (cfg.index == prlru_pkg::REG_FRAMES_IN_USE) begin
				if (cfg.data == '0) begin
					n_q <= RANK_W'(1);
				end else if (int'(cfg.data) > FRAMES) begin
					n_q <= RANK_W'(FRAMES);
				end else begin
					n_q <= RANK_W'(cfg.data);
				end
			end
		end
	end

	// Only writes to a known register clear the table.
	logic cfg_clear;
	assign cfg_clear = cfg_wr && (cfg.index == prlru_pkg::REG_POLICY ||
		cfg.index == prlru_pkg::REG_FRAMES_IN_USE);

	// Input register.
	logic             valid_s1;
	prlru_pkg::page_t page_s1;
	logic             advance;

	assign advance   = valid_s1 && (!rsp.valid || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_s1 <= req.page_number;
		end
	end

	// Lookup and update, done in the cycle the item leaves the input register.
	prlru_pkg::prlru_ctl_t  ctl;
	prlru_pkg::prlru_look_t look;
	logic [IDX_W-1:0]       slot;

	assign ctl.clear  = cfg_clear;
	assign ctl.step   = advance;
	assign ctl.policy = policy_q;

	prlru_table #(
		.FRAMES(FRAMES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.n     (n_q),
		.page  (page_s1),
		.look  (look),
		.slot  (slot)
	);

	// Output register.
	logic             rsp_valid_q;
	logic             hit_q;
	prlru_pkg::fidx_t frame_index_q;
	logic             ev_valid_q;
	prlru_pkg::page_t ev_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp.ready) begin
			rsp_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q         <= look.hit;
			frame_index_q <= prlru_pkg::fidx_t'(slot);
			ev_valid_q    <= look.ev_valid;
			ev_page_q     <= look.ev_page;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.frame_index   = frame_index_q;
	assign rsp.evicted_valid = ev_valid_q;
	assign rsp.evicted_page  = ev_page_q;

endmodule

`default_nettype wire

@@ sv/prlru_checker.sv @@
// Port-level checks for page_replacement_fifo_lru_core, bound to the top.
// Depends on prlru_pkg and the top level's channel interfaces.
`default_nettype none

module prlru_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic             rsp_hit,
	input wire prlru_pkg::fidx_t rsp_frame_index,
	input wire logic             rsp_evicted_valid,
	input wire prlru_pkg::page_t rsp_evicted_page
);

	logic req_beat;
	assign req_beat = req_valid && req_ready;

	// A stalled result beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
		$stable(rsp_frame_index) && $stable(rsp_evicted_valid) &&
		$stable(rsp_evicted_page))
		else $error("result beat changed while stalled");

	// A hit never displaces a page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_hit && rsp_evicted_valid))
		else $error("hit reported together with an eviction");

	// The evicted page field is zero when nothing was displaced.
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
		else $error("evicted page not zero without an eviction");

	// No result appears without a reference accepted shortly before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid && !req_beat) ##1 (!rsp_valid && !req_beat) |=> !rsp_valid)
		else $error("result beat without an accepted reference");

endmodule

bind page_replacement_fifo_lru_core prlru_checker u_prlru_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_hit          (rsp.hit),
	.rsp_frame_index  (rsp.frame_index),
	.rsp_evicted_valid(rsp.evicted_valid),
	.rsp_evicted_page (rsp.evicted_page)
);

`default_nettype wire
